// ----- hdl/vsqm_pkg.sv -----
// ----------------------------------------------------------------------------
// Voxel surface quad mesher package
// Shared widths, record types and cube corner tables for the mesher.
// ----------------------------------------------------------------------------
package vsqm_pkg;

	localparam int COORD_W       = 6;
	localparam int MASK_W        = 6;
	localparam int CORNER_W      = 7;
	localparam int ID_W          = 19;
	localparam int FACE_W        = 21;
	localparam int NUM_FACES     = 6;
	localparam int DEF_GRID_SIZE = 64;

	localparam logic KIND_VERTEX = 1'b0;
	localparam logic KIND_QUAD   = 1'b1;

	// Corners of each face, in face order z-1, x-1, y+1, x+1, y-1, z+1.
	localparam logic [2:0] FACE_CORNERS [NUM_FACES][4] = '{
		'{3'd3, 3'd2, 3'd1, 3'd0},
		'{3'd3, 3'd0, 3'd4, 3'd7},
		'{3'd2, 3'd3, 3'd7, 3'd6},
		'{3'd1, 3'd2, 3'd6, 3'd5},
		'{3'd0, 3'd1, 3'd5, 3'd4},
		'{3'd4, 3'd5, 3'd6, 3'd7}
	};

	// Bit c gives the offset of cube corner c along each axis.
	localparam logic [7:0] OFF_X = 8'b0110_0110;
	localparam logic [7:0] OFF_Y = 8'b1100_1100;
	localparam logic [7:0] OFF_Z = 8'b1111_0000;

	typedef struct packed {
		logic [COORD_W-1:0] voxel_x;
		logic [COORD_W-1:0] voxel_y;
		logic [COORD_W-1:0] voxel_z;
		logic [MASK_W-1:0]  exposed_mask;
	} vsqm_voxel_t;

	typedef struct packed {
		logic                record_kind;
		logic [ID_W-1:0]     new_vertex_id;
		logic [CORNER_W-1:0] corner_x;
		logic [CORNER_W-1:0] corner_y;
		logic [CORNER_W-1:0] corner_z;
		logic [ID_W-1:0]     quad_id0;
		logic [ID_W-1:0]     quad_id1;
		logic [ID_W-1:0]     quad_id2;
		logic [ID_W-1:0]     quad_id3;
		logic [ID_W-1:0]     vertices_so_far;
		logic [FACE_W-1:0]   faces_so_far;
		logic                last_record;
	} vsqm_record_t;

endpackage

// ----- hdl/voxel_surface_quad_mesher_core.sv -----
// ----------------------------------------------------------------------------
// Voxel surface quad mesher core
// Turns surface voxels into welded vertex records and quad face records.
// ----------------------------------------------------------------------------
// Usage: drive a voxel (grid coordinate and exposed-neighbor mask) on voxel and
// raise start; the transfer happens at the clock edge where start is high and
// busy is low. The block then emits its records on rec, one per cycle at most,
// each marked by a single-cycle rec_strobe; the receiver cannot stall them.
// The final record of a voxel carries last_record. A voxel with an empty mask
// or a coordinate outside the grid is taken and dropped without a record.
//
// Timing: after the transfer the corner-table base address is formed first.
// Each exposed face then takes four corner-table reads through the single read
// port, a drain cycle and a quad cycle; the first read of every further face
// overlaps the quad cycle of the face before. The last record shows in the
// cycle in which busy falls.
//
// Reset: the corner table is cleared by a pass that writes one entry per
// cycle to all (GRID_SIZE+1)^3 entries (274625 by default), with busy high.
// The vertex and face counters reset to zero.
// ----------------------------------------------------------------------------
module voxel_surface_quad_mesher_core #(
	parameter int GRID_SIZE = vsqm_pkg::DEF_GRID_SIZE
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  vsqm_pkg::vsqm_voxel_t  voxel,
	output logic                   rec_strobe,
	output vsqm_pkg::vsqm_record_t rec
);
	import vsqm_pkg::*;

	// Corner grid spans one more point than the voxel grid on each axis.
	localparam int SPAN  = GRID_SIZE + 1;
	localparam int DEPTH = SPAN * SPAN * SPAN;
	localparam int AW    = $clog2(DEPTH);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_BASE  = 2'd2;
	localparam logic [1:0] ST_RUN   = 2'd3;

	// Phases of one face: four reads, a drain cycle, then the quad cycle.
	localparam logic [2:0] PH_DRAIN = 3'd4;
	localparam logic [2:0] PH_QUAD  = 3'd5;

	typedef struct packed {
		logic            valid;
		logic [ID_W-1:0] id;
	} vsqm_entry_t;

	function automatic logic [AW-1:0] corner_off(input logic [2:0] c);
		int off;
		off = int'(OFF_X[c]) * SPAN * SPAN + int'(OFF_Y[c]) * SPAN + int'(OFF_Z[c]);
		return AW'(off);
	endfunction

	function automatic logic [2:0] lowest_face(input logic [MASK_W-1:0] m);
		logic [2:0] r;
		r = '0;
		for (int i = NUM_FACES - 1; i >= 0; i--) begin
			if (m[i]) begin
				r = 3'(i);
			end
		end
		return r;
	endfunction

	// Corner table: valid bit and vertex ID per grid corner.
	vsqm_entry_t mem [DEPTH];
	vsqm_entry_t mem_rd_s1;

	logic [1:0]          state_q;
	logic [2:0]          phase_q;
	logic [2:0]          face_q;
	logic [MASK_W-1:0]   rem_q;
	logic [AW-1:0]       clr_addr_q;
	logic [ID_W-1:0]     vcount_q;
	logic [FACE_W-1:0]   fcount_q;
	logic [COORD_W-1:0]  vx_q, vy_q, vz_q;
	logic [AW-1:0]       row_q;
	logic [AW-1:0]       base_q;
	logic [ID_W-1:0]     ids_q [4];

	logic                rd_v_s1;
	logic [1:0]          rd_k_s1;
	logic [AW-1:0]       rd_addr_s1;
	logic [CORNER_W-1:0] rd_cx_s1, rd_cy_s1, rd_cz_s1;

	logic                rec_strobe_q;
	vsqm_record_t        rec_q;

	logic                in_grid;
	logic [MASK_W-1:0]   rem_after;
	logic [2:0]          nxt_face;
	logic                quad_cycle;
	logic                issue;
	logic [2:0]          iss_face;
	logic [1:0]          iss_k;
	logic [2:0]          iss_c;
	logic [AW-1:0]       iss_addr;
	logic                new_vtx;
	logic                mem_we;
	logic [AW-1:0]       mem_waddr;
	vsqm_entry_t         mem_wdata;
	logic [FACE_W-1:0]   fcount_inc;
	vsqm_record_t        rec_d;

	assign busy       = (state_q != ST_IDLE);
	assign rec_strobe = rec_strobe_q;
	assign rec        = rec_q;

	assign in_grid = ({{(32-COORD_W){1'b0}}, voxel.voxel_x} < GRID_SIZE)
		&& ({{(32-COORD_W){1'b0}}, voxel.voxel_y} < GRID_SIZE)
		&& ({{(32-COORD_W){1'b0}}, voxel.voxel_z} < GRID_SIZE);

	assign rem_after  = rem_q & ~(MASK_W'(1) << face_q);
	assign nxt_face   = lowest_face(rem_after);
	assign quad_cycle = (state_q == ST_RUN) && (phase_q == PH_QUAD);

	// The quad cycle already issues the first read of the next face. Reads and
	// writes of the same cycle always address different corners of one face,
	// and a corner read later sees every earlier write, so no forwarding is
	// needed in this schedule.
	assign issue = (state_q == ST_RUN)
		&& ((phase_q < PH_DRAIN) || (quad_cycle && (rem_after != '0)));
	assign iss_face = quad_cycle ? nxt_face : face_q;
	assign iss_k    = quad_cycle ? 2'd0 : phase_q[1:0];
	assign iss_c    = FACE_CORNERS[iss_face][iss_k];
	assign iss_addr = base_q + corner_off(iss_c);

	// A corner whose entry is not yet valid is given the next vertex ID.
	assign new_vtx   = rd_v_s1 && !mem_rd_s1.valid;
	assign mem_we    = (state_q == ST_CLEAR) || new_vtx;
	assign mem_waddr = (state_q == ST_CLEAR) ? clr_addr_q : rd_addr_s1;
	assign mem_wdata = (state_q == ST_CLEAR) ? '0 : vsqm_entry_t'{valid: 1'b1, id: vcount_q};

	assign fcount_inc = (fcount_q == '1) ? fcount_q : fcount_q + FACE_W'(1);

	always_comb begin
		rec_d = '0;
		if (new_vtx) begin
			rec_d.record_kind     = KIND_VERTEX;
			rec_d.new_vertex_id   = vcount_q;
			rec_d.corner_x        = rd_cx_s1;
			rec_d.corner_y        = rd_cy_s1;
			rec_d.corner_z        = rd_cz_s1;
			rec_d.vertices_so_far = vcount_q + ID_W'(1);
			rec_d.faces_so_far    = fcount_q;
		end else begin
			rec_d.record_kind     = KIND_QUAD;
			rec_d.quad_id0        = ids_q[0];
			rec_d.quad_id1        = ids_q[1];
			rec_d.quad_id2        = ids_q[2];
			rec_d.quad_id3        = ids_q[3];
			rec_d.vertices_so_far = vcount_q;
			rec_d.faces_so_far    = fcount_inc;
			rec_d.last_record     = (rem_after == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			mem_rd_s1 <= mem[iss_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			phase_q      <= '0;
			face_q       <= '0;
			rem_q        <= '0;
			clr_addr_q   <= '0;
			vcount_q     <= '0;
			fcount_q     <= '0;
			rd_v_s1      <= 1'b0;
			rec_strobe_q <= 1'b0;
		end else begin
			rd_v_s1      <= issue;
			rec_strobe_q <= new_vtx || quad_cycle;
			if (new_vtx) begin
				vcount_q <= vcount_q + ID_W'(1);
			end
			if (quad_cycle) begin
				fcount_q <= fcount_inc;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + AW'(1);
					if (clr_addr_q == AW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start && in_grid && (voxel.exposed_mask != '0)) begin
						rem_q   <= voxel.exposed_mask;
						state_q <= ST_BASE;
					end
				end
				ST_BASE: begin
					face_q  <= lowest_face(rem_q);
					phase_q <= '0;
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (quad_cycle) begin
						rem_q <= rem_after;
						if (rem_after == '0) begin
							state_q <= ST_IDLE;
						end else begin
							face_q  <= nxt_face;
							phase_q <= 3'd1;
						end
					end else begin
						phase_q <= phase_q + 3'd1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && start) begin
			vx_q  <= voxel.voxel_x;
			vy_q  <= voxel.voxel_y;
			vz_q  <= voxel.voxel_z;
			row_q <= AW'(voxel.voxel_x) * AW'(SPAN) + AW'(voxel.voxel_y);
		end
		if (state_q == ST_BASE) begin
			base_q <= row_q * AW'(SPAN) + AW'(vz_q);
		end
		if (issue) begin
			rd_k_s1    <= iss_k;
			rd_addr_s1 <= iss_addr;
			rd_cx_s1   <= CORNER_W'(vx_q) + CORNER_W'(OFF_X[iss_c]);
			rd_cy_s1   <= CORNER_W'(vy_q) + CORNER_W'(OFF_Y[iss_c]);
			rd_cz_s1   <= CORNER_W'(vz_q) + CORNER_W'(OFF_Z[iss_c]);
		end
		if (rd_v_s1) begin
			ids_q[rd_k_s1] <= new_vtx ? vcount_q : mem_rd_s1.id;
		end
		if (new_vtx || quad_cycle) begin
			rec_q <= rec_d;
		end
	end

endmodule

// ----- hdl/vsqm_checker.sv -----
// ----------------------------------------------------------------------------
// Voxel surface quad mesher checker
// Port-level checks of the record stream, bound to the mesher core.
// ----------------------------------------------------------------------------
module vsqm_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   start,
	input logic                   busy,
	input vsqm_pkg::vsqm_voxel_t  voxel,
	input logic                   rec_strobe,
	input vsqm_pkg::vsqm_record_t rec
);
	import vsqm_pkg::*;

	// A new vertex is always followed by the quad of its face.
	a_vertex_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(rec_strobe && (rec.record_kind == KIND_VERTEX)) |-> !rec.last_record)
		else $error("vertex record flagged as last");

	// The running vertex count includes the vertex just created.
	a_vertex_count: assert property (@(posedge clk) disable iff (!arst_n)
		(rec_strobe && (rec.record_kind == KIND_VERTEX))
		|-> (rec.vertices_so_far == (rec.new_vertex_id + 19'd1)))
		else $error("vertex count does not follow the new vertex ID");

	// A voxel with no exposed face produces nothing and frees the block at once.
	a_empty_mask: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (voxel.exposed_mask == '0)) |=> (!busy && !rec_strobe))
		else $error("empty voxel made the block busy or produced a record");

	// The last record of a voxel is never directly followed by another.
	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(rec_strobe && rec.last_record) |=> !rec_strobe)
		else $error("record right after the last record of a voxel");

endmodule

bind voxel_surface_quad_mesher_core vsqm_checker u_vsqm_checker (.*);
